@@ hw/rtl/ffd_pkg.sv @@
`timescale 1ns / 1ps

package ffd_pkg;

   // Frame layout: sync(3), spare(1), id(4), size(4), header check(4), payload check(4).
   localparam int HEADER_BYTES  = 20;
   localparam int CHECKED_BYTES = HEADER_BYTES - 8;
   localparam int STORE_DEPTH   = HEADER_BYTES - 4;
   localparam int STORE_IDX_W   = $clog2(STORE_DEPTH);

   localparam logic [7:0] SYNC_1 = 8'ha3;
   localparam logic [7:0] SYNC_2 = 8'hb2;
   localparam logic [7:0] SYNC_3 = 8'hc1;

   localparam logic [15:0] FL_INIT          = 16'hffff;
   localparam logic [15:0] SIZE_LIMIT_RESET = 16'd1024;

   localparam logic ITEM_PAYLOAD = 1'b0;
   localparam logic ITEM_VERDICT = 1'b1;

   localparam logic [1:0] STATUS_GOOD      = 2'd0;
   localparam logic [1:0] STATUS_BAD_HDR   = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHECK = 2'd2;
   localparam logic [1:0] STATUS_TRUNC     = 2'd3;

   localparam int RSP_FIELDS_W = 8 + 32 + 16 + 2 + 32 + 32 + 32;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic        item_type;
      logic [7:0]  payload_byte;
      logic [31:0] message_id;
      logic [15:0] message_size;
      logic [1:0]  status;
      logic [31:0] good_frames;
      logic [31:0] bad_headers;
      logic [31:0] bad_payloads;
   } ffd_result_type;

   // One Fletcher-32 word step with end-around carry fold on both sums.
   // Returns {sum_high, sum_low}.
   function automatic logic [31:0] fl_update(input logic [15:0] s1,
                                             input logic [15:0] s2,
                                             input logic [15:0] w);
      logic [16:0] a1;
      logic [15:0] n1;
      logic [16:0] a2;
      logic [15:0] n2;
      a1 = {1'b0, s1} + {1'b0, w};
      n1 = a1[15:0] + {15'd0, a1[16]};
      a2 = {1'b0, s2} + {1'b0, n1};
      n2 = a2[15:0] + {15'd0, a2[16]};
      return {n2, n1};
   endfunction

   // Sums after the first sync word; the third sync byte waits as the odd byte.
   localparam logic [31:0] SYNC_SUMS = fl_update(FL_INIT, FL_INIT, {SYNC_2, SYNC_1});

endpackage

@@ hw/rtl/ffd_core.sv @@
`timescale 1ns / 1ps

module ffd_core
   import ffd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     in_byte,
   input  logic           in_end,
   input  logic [15:0]    size_limit,
   output logic           res_valid,
   output ffd_result_type res
);

   localparam logic [2:0] PH_HUNT1   = 3'd0;
   localparam logic [2:0] PH_HUNT2   = 3'd1;
   localparam logic [2:0] PH_HUNT3   = 3'd2;
   localparam logic [2:0] PH_HEADER  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] s1_ff, s1_in;
   logic [15:0] s2_ff, s2_in;
   logic        odd_v_ff, odd_v_in;
   logic [7:0]  odd_b_ff, odd_b_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] bad_hdr_ff, bad_hdr_in;
   logic [31:0] bad_chk_ff, bad_chk_in;
   logic [7:0]  store_ff [STORE_DEPTH];

   logic                   store_we;
   logic [STORE_IDX_W-1:0] store_idx;
   logic [15:0]            pos_next;
   logic [15:0]            word;
   logic [31:0]            upd;
   logic [31:0]            id_word, size_word, hcheck_word, pcheck_word;
   logic                   size_ok;

   assign pos_next    = pos_ff + 16'd1;
   assign word        = odd_v_ff ? {in_byte, odd_b_ff} : {8'd0, in_byte};
   assign upd         = fl_update(s1_ff, s2_ff, word);
   assign store_idx   = pos_ff[STORE_IDX_W-1:0] - STORE_IDX_W'(4);
   assign id_word     = {store_ff[3], store_ff[2], store_ff[1], store_ff[0]};
   assign size_word   = {store_ff[7], store_ff[6], store_ff[5], store_ff[4]};
   assign hcheck_word = {store_ff[11], store_ff[10], store_ff[9], store_ff[8]};
   assign pcheck_word = {store_ff[15], store_ff[14], store_ff[13], store_ff[12]};
   assign size_ok     = (size_word >= 32'(HEADER_BYTES)) && (size_word < {16'd0, size_limit});

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      s1_in      = s1_ff;
      s2_in      = s2_ff;
      odd_v_in   = odd_v_ff;
      odd_b_in   = odd_b_ff;
      good_in    = good_ff;
      bad_hdr_in = bad_hdr_ff;
      bad_chk_in = bad_chk_ff;
      store_we   = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      unique case (phase_ff)
         PH_HEADER: begin
            if (pos_ff < 16'(CHECKED_BYTES)) begin
               if (odd_v_ff) begin
                  {s2_in, s1_in} = upd;
                  odd_v_in       = 1'b0;
               end else begin
                  odd_b_in = in_byte;
                  odd_v_in = 1'b1;
               end
            end
            store_we = (pos_ff >= 16'd4);
            pos_in   = pos_next;
            if (pos_next < 16'(HEADER_BYTES)) begin
               if (in_end) begin
                  phase_in   = PH_HUNT1;
                  res_valid  = 1'b1;
                  res.item_type = ITEM_VERDICT;
                  res.status = STATUS_TRUNC;
               end
            end else if (({s2_ff, s1_ff} != hcheck_word) || !size_ok) begin
               // The header check covers only the first twelve bytes, all summed by now.
               bad_hdr_in       = bad_hdr_ff + 32'd1;
               phase_in         = PH_HUNT1;
               res_valid        = 1'b1;
               res.item_type    = ITEM_VERDICT;
               res.message_id   = id_word;
               res.message_size = size_word[15:0];
               res.status       = STATUS_BAD_HDR;
            end else begin
               s1_in            = FL_INIT;
               s2_in            = FL_INIT;
               odd_v_in         = 1'b0;
               res.item_type    = ITEM_VERDICT;
               res.message_id   = id_word;
               res.message_size = size_word[15:0];
               if (size_word == 32'(HEADER_BYTES)) begin
                  // Empty payload: its check is the initial sums, and the top byte of the
                  // expected value is the byte arriving now.
                  phase_in  = PH_HUNT1;
                  res_valid = 1'b1;
                  if ({in_byte, pcheck_word[23:0]} == {FL_INIT, FL_INIT}) begin
                     good_in    = good_ff + 32'd1;
                     res.status = STATUS_GOOD;
                  end else begin
                     bad_chk_in = bad_chk_ff + 32'd1;
                     res.status = STATUS_BAD_CHECK;
                  end
               end else if (in_end) begin
                  phase_in   = PH_HUNT1;
                  res_valid  = 1'b1;
                  res.status = STATUS_TRUNC;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end

         PH_PAYLOAD: begin
            pos_in           = pos_next;
            res_valid        = 1'b1;
            res.payload_byte = in_byte;
            if (odd_v_ff) begin
               {s2_in, s1_in} = upd;
               odd_v_in       = 1'b0;
            end else begin
               odd_b_in = in_byte;
               odd_v_in = 1'b1;
            end
            if ({16'd0, pos_next} >= size_word) begin
               // Last byte: the padded final word is folded in the same step.
               phase_in         = PH_HUNT1;
               res.item_type    = ITEM_VERDICT;
               res.message_id   = id_word;
               res.message_size = size_word[15:0];
               if (upd == pcheck_word) begin
                  good_in    = good_ff + 32'd1;
                  res.status = STATUS_GOOD;
               end else begin
                  bad_chk_in = bad_chk_ff + 32'd1;
                  res.status = STATUS_BAD_CHECK;
               end
            end else if (in_end) begin
               phase_in         = PH_HUNT1;
               res.item_type    = ITEM_VERDICT;
               res.message_id   = id_word;
               res.message_size = size_word[15:0];
               res.status       = STATUS_TRUNC;
            end else begin
               res.item_type = ITEM_PAYLOAD;
            end
         end

         PH_HUNT1, PH_HUNT2, PH_HUNT3: begin
            if (phase_ff == PH_HUNT3 && in_byte == SYNC_3) begin
               {s2_in, s1_in} = SYNC_SUMS;
               odd_v_in       = 1'b1;
               odd_b_in       = SYNC_3;
               pos_in         = 16'd3;
               phase_in       = PH_HEADER;
               if (in_end) begin
                  phase_in      = PH_HUNT1;
                  res_valid     = 1'b1;
                  res.item_type = ITEM_VERDICT;
                  res.status    = STATUS_TRUNC;
               end
            end else begin
               // A first sync byte restarts the match, even mid-pattern, unless it ends a datagram.
               priority if (in_end)                                   phase_in = PH_HUNT1;
               else if (in_byte == SYNC_1)                            phase_in = PH_HUNT2;
               else if (phase_ff == PH_HUNT2 && in_byte == SYNC_2)   phase_in = PH_HUNT3;
               else                                                   phase_in = PH_HUNT1;
            end
         end

         default: begin
            phase_in = PH_HUNT1;
         end
      endcase

      res.good_frames  = good_in;
      res.bad_headers  = bad_hdr_in;
      res.bad_payloads = bad_chk_in;
      if (!step) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT1;
         pos_ff     <= '0;
         s1_ff      <= FL_INIT;
         s2_ff      <= FL_INIT;
         odd_v_ff   <= 1'b0;
         good_ff    <= '0;
         bad_hdr_ff <= '0;
         bad_chk_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         odd_v_ff   <= odd_v_in;
         good_ff    <= good_in;
         bad_hdr_ff <= bad_hdr_in;
         bad_chk_ff <= bad_chk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         odd_b_ff <= odd_b_in;
      end
      if (step && store_we) begin
         store_ff[store_idx] <= in_byte;
      end
   end

endmodule

@@ hw/rtl/ffd_out_reg.sv @@
`timescale 1ns / 1ps

module ffd_out_reg
   import ffd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  logic           load_valid,
   input  ffd_result_type load_item,
   input  logic           out_ready,
   output logic           space,
   output logic           out_valid,
   output ffd_result_type out_item
);

   logic           valid_ff, valid_in;
   ffd_result_type item_ff;

   // The slot frees in the same cycle that the consumer takes the held item.
   assign space = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = load_valid;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         item_ff <= load_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ hw/rtl/fletcher_frame_deframer.sv @@
`timescale 1ns / 1ps

// Sync-word deframer with Fletcher-32 checks. The block takes one datagram byte per item,
// hunts for the sync pattern A3 B2 C1, gathers the 20-byte little-endian header and accepts
// it only if the Fletcher-32 over its first twelve bytes matches the header check and the
// frame size is at least 20 and below the size limit register (reset 1024). Payload bytes
// then stream out one item each, and every frame closes with one verdict item (tuser high,
// tlast high) that carries the status, the three running counters and, once the header
// is complete, the id and size; that verdict takes the place of the last payload byte and
// carries it. Frames cut off by the end of a datagram give a truncated verdict and are not
// counted. Throughput is one byte per clock cycle sustained while the result side keeps
// up: a byte is held in an input register, from which the sync match, header capture and
// one Fletcher-32 word step run through a single stage into the result register, which
// offers the result. A result left waiting holds the following byte in the input register,
// and the input stalls once both registers are occupied. That one-word checksum step is the
// longest path in the block. The user must write the size limit over the csr port only
// while the block is idle; the block itself does not enforce this.

module fletcher_frame_deframer
   import ffd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic                  req_tlast,   // datagram_end
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // From bit 0 up: payload_byte[7:0], message_id[39:8], message_size[55:40],
   // status[57:56], good_frames[89:58], bad_headers[121:90], bad_payloads[153:122],
   // zero fill[159:154].
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // item_type
   output logic                  rsp_tlast,   // frame_last
   // Size limit register write.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_end_ff;
   logic [15:0]    size_limit_ff;
   logic           advance;
   logic           space;
   logic           res_valid;
   ffd_result_type res;
   ffd_result_type out_item;

   // The held byte moves on whenever the result register can take its outcome.
   assign advance    = in_valid_ff && space;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         size_limit_ff <= SIZE_LIMIT_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (csr_valid) begin
            size_limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   ffd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_byte    (in_byte_ff),
      .in_end     (in_end_ff),
      .size_limit (size_limit_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   ffd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (res_valid),
      .load_item  (res),
      .out_ready  (rsp_tready),
      .space      (space),
      .out_valid  (rsp_tvalid),
      .out_item   (out_item)
   );

   assign rsp_tuser = out_item.item_type;
   assign rsp_tlast = out_item.item_type;
   assign rsp_tdata = {(RSP_DATA_W - RSP_FIELDS_W)'(0),
                       out_item.bad_payloads,
                       out_item.bad_headers,
                       out_item.good_frames,
                       out_item.status,
                       out_item.message_size,
                       out_item.message_id,
                       out_item.payload_byte};

endmodule

@@ hw/rtl/ffd_checker.sv @@
`timescale 1ns / 1ps

module ffd_checker
   import ffd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   // Every verdict closes a frame and nothing else does.
   a_last_is_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser))
      else $error("frame end flag disagrees with item type");

   // Payload items carry no id, size or status.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[57:8] == '0))
      else $error("payload item carries verdict fields");

   // A waiting result holds until taken.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result changed while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind fletcher_frame_deframer ffd_checker u_ffd_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the sync-word deframer. An initial block fills a queue with
// datagram bytes: a few hand-made sequences first, then mostly well-formed frames with
// random content, mixed with noise and broken frames. A clocked driver feeds that queue
// into the block and, at each accepted byte, runs a local model of the deframer that
// queues the result item the byte should produce. A clocked monitor compares every
// accepted result with the oldest queued one, field by field.

module tb;
   import ffd_pkg::*;

   // This margin lets the input and result registers empty of bytes that produce no item.
   localparam int DRAIN_CYCLES = 10;
   // Length of the long receiver hold-off that forces the input side to back up.
   localparam int HOLD_CYCLES  = 500;
   // Cycles without any handshake before the run is declared hung.
   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 190;

   typedef enum logic [2:0] {
      SEEK_A3,
      SEEK_B2,
      SEEK_C1,
      TAKE_HEADER,
      TAKE_PAYLOAD
   } seek_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       datagram_end;
   } rx_byte_type;

   typedef struct packed {
      logic        item_type;
      logic [7:0]  payload_byte;
      logic [31:0] message_id;
      logic [15:0] message_size;
      logic [1:0]  status;
      logic [31:0] good_frames;
      logic [31:0] bad_headers;
      logic [31:0] bad_payloads;
      logic        frame_last;
   } frame_item_type;

   typedef logic [7:0] byte_q_type[$];

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [15:0]           csr_data;

   fletcher_frame_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Stimulus and expectation stores.
   rx_byte_type    rx_bytes_q[$];
   frame_item_type awaited_results[$];
   int unsigned items_queued   = 0;
   int unsigned items_accepted = 0;
   int unsigned mismatches     = 0;

   // Idling controls, changed by the sequence between phases.
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_requests      = 0;
   int unsigned holds_started      = 0;
   int unsigned hold_left          = 0;
   int unsigned quiet_cycles       = 0;

   // Local copy of the deframer state and of its size limit register.
   seek_state_type seek = SEEK_A3;
   logic [7:0]  hdr_mem[STORE_DEPTH];
   logic [15:0] frame_pos = '0;
   logic [31:0] sums = {FL_INIT, FL_INIT};   // {high sum, low sum}
   logic        odd_held = 1'b0;
   logic [7:0]  odd_val = '0;
   logic [31:0] n_good = '0;
   logic [31:0] n_bad_hdr = '0;
   logic [31:0] n_bad_check = '0;
   logic [15:0] limit_reg = SIZE_LIMIT_RESET;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Fletcher-32 arithmetic.
   // ---------------------------------------------------------------------------------

   // One 16-bit word into the pair of sums, with the end-around carry on each sum.
   function automatic logic [31:0] fletcher_step(logic [31:0] s, logic [15:0] w);
      int unsigned acc;
      logic [15:0] lo;
      logic [15:0] hi;
      acc = s[15:0] + w;
      lo  = acc[15:0] + acc[31:16];
      acc = s[31:16] + lo;
      hi  = acc[15:0] + acc[31:16];
      return {hi, lo};
   endfunction

   // Check over a whole byte string, low byte first, an odd tail padded with zero.
   function automatic logic [31:0] fletcher_of(byte_q_type bytes_in);
      logic [31:0] s;
      logic [7:0]  upper;
      s = {FL_INIT, FL_INIT};
      for (int k = 0; k < bytes_in.size(); k += 2) begin
         upper = (k + 1 < bytes_in.size()) ? bytes_in[k + 1] : 8'h00;
         s = fletcher_step(s, {upper, bytes_in[k]});
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------------------
   // Deframer model. It runs once per accepted byte and queues the item that byte
   // should produce, if any.
   // ---------------------------------------------------------------------------------

   function automatic void sum_restart();
      sums     = {FL_INIT, FL_INIT};
      odd_held = 1'b0;
      odd_val  = '0;
   endfunction

   // Bytes pair up into words; the first of a pair waits as the odd byte.
   function automatic void sum_byte(logic [7:0] b);
      if (odd_held) begin
         sums     = fletcher_step(sums, {b, odd_val});
         odd_held = 1'b0;
      end else begin
         odd_val  = b;
         odd_held = 1'b1;
      end
   endfunction

   function automatic logic [31:0] sum_close();
      if (odd_held) begin
         sums     = fletcher_step(sums, {8'h00, odd_val});
         odd_held = 1'b0;
      end
      return sums;
   endfunction

   // The header store is a ring of sixteen bytes, indexed from header byte 4.
   function automatic logic [31:0] hdr_word(int unsigned at);
      return {hdr_mem[(at + 3) % STORE_DEPTH], hdr_mem[(at + 2) % STORE_DEPTH],
              hdr_mem[(at + 1) % STORE_DEPTH], hdr_mem[at % STORE_DEPTH]};
   endfunction

   // The counters in an item are the ones after the byte has been taken.
   function automatic void push_result(logic kind, logic [7:0] b, logic [31:0] id,
                                       logic [31:0] sz, logic [1:0] st);
      frame_item_type r;
      r.item_type    = kind;
      r.payload_byte = b;
      r.message_id   = id;
      r.message_size = sz[15:0];
      r.status       = st;
      r.good_frames  = n_good;
      r.bad_headers  = n_bad_hdr;
      r.bad_payloads = n_bad_check;
      r.frame_last   = kind;
      awaited_results.push_back(r);
   endfunction

   // The verdict of a completed frame replaces its last payload item.
   function automatic void close_frame(logic [7:0] b);
      logic [1:0] st;
      seek = SEEK_A3;
      if (sum_close() == hdr_word(12)) begin
         n_good++;
         st = STATUS_GOOD;
      end else begin
         n_bad_check++;
         st = STATUS_BAD_CHECK;
      end
      push_result(ITEM_VERDICT, b, hdr_word(0), hdr_word(4), st);
   endfunction

   function automatic void deframe_byte(logic [7:0] b, logic dg_end);
      int unsigned p;
      logic [31:0] id;
      logic [31:0] sz;
      logic [31:0] got;
      if (seek == TAKE_HEADER) begin
         p = frame_pos;
         if (p < CHECKED_BYTES)
            sum_byte(b);
         if (p >= 4)
            hdr_mem[(p - 4) % STORE_DEPTH] = b;
         frame_pos = 16'(p + 1);
         if (frame_pos < HEADER_BYTES) begin
            // A header cut off by the datagram end carries neither id nor size.
            if (dg_end) begin
               seek = SEEK_A3;
               push_result(ITEM_VERDICT, 8'h00, '0, '0, STATUS_TRUNC);
            end
            return;
         end
         id  = hdr_word(0);
         sz  = hdr_word(4);
         got = sum_close();
         // The size is compared at its full 32 bits.
         if (got != hdr_word(8) || sz < HEADER_BYTES || sz >= {16'h0000, limit_reg}) begin
            n_bad_hdr++;
            seek = SEEK_A3;
            push_result(ITEM_VERDICT, 8'h00, id, sz, STATUS_BAD_HDR);
            return;
         end
         sum_restart();
         if (sz == HEADER_BYTES) begin
            close_frame(8'h00);
            return;
         end
         seek = TAKE_PAYLOAD;
         if (dg_end) begin
            seek = SEEK_A3;
            push_result(ITEM_VERDICT, 8'h00, id, sz, STATUS_TRUNC);
         end
         return;
      end

      if (seek == TAKE_PAYLOAD) begin
         sz = hdr_word(4);
         sum_byte(b);
         frame_pos = frame_pos + 16'd1;
         if ({16'h0000, frame_pos} >= sz) begin
            close_frame(b);
         end else if (dg_end) begin
            seek = SEEK_A3;
            push_result(ITEM_VERDICT, b, hdr_word(0), sz, STATUS_TRUNC);
         end else begin
            push_result(ITEM_PAYLOAD, b, '0, '0, STATUS_GOOD);
         end
         return;
      end

      if (seek == SEEK_C1 && b == SYNC_3) begin
         sum_restart();
         sums = fletcher_step(sums, {SYNC_2, SYNC_1});
         sum_byte(SYNC_3);
         frame_pos = 16'd3;
         seek = TAKE_HEADER;
         if (dg_end) begin
            seek = SEEK_A3;
            push_result(ITEM_VERDICT, 8'h00, '0, '0, STATUS_TRUNC);
         end
         return;
      end

      // A first sync byte always restarts the match, so overlapping syncs are found.
      if (b == SYNC_1)
         seek = SEEK_B2;
      else if (seek == SEEK_B2 && b == SYNC_2)
         seek = SEEK_C1;
      else
         seek = SEEK_A3;
      // A partial sync never survives the end of a datagram.
      if (dg_end)
         seek = SEEK_A3;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus generation.
   // ---------------------------------------------------------------------------------

   task automatic queue_byte(logic [7:0] b, logic dg_end);
      rx_byte_type item;
      item.data_byte    = b;
      item.datagram_end = dg_end;
      rx_bytes_q.push_back(item);
      items_queued++;
   endtask

   // Builds one frame. A cut position below zero sends the whole frame; otherwise the
   // datagram ends on that frame byte and the rest is never sent.
   task automatic add_frame(logic [31:0] id, logic [31:0] sz, int unsigned body_len,
                            bit bad_hdr_sum, bit bad_body_sum, int cut_at,
                            bit end_on_last);
      byte_q_type  frame;
      byte_q_type  body;
      logic [31:0] hdr_sum;
      logic [31:0] body_sum;
      logic [7:0]  b;
      int          last;
      frame.push_back(SYNC_1);
      frame.push_back(SYNC_2);
      frame.push_back(SYNC_3);
      b = 8'($urandom_range(255, 0));
      frame.push_back(b);
      for (int k = 0; k < 4; k++)
         frame.push_back(id[8 * k +: 8]);
      for (int k = 0; k < 4; k++)
         frame.push_back(sz[8 * k +: 8]);
      hdr_sum = fletcher_of(frame);
      if (bad_hdr_sum)
         hdr_sum ^= 32'h1 << $urandom_range(31, 0);
      for (int k = 0; k < body_len; k++) begin
         b = 8'($urandom_range(255, 0));
         body.push_back(b);
      end
      body_sum = fletcher_of(body);
      if (bad_body_sum)
         body_sum ^= 32'h1 << $urandom_range(31, 0);
      for (int k = 0; k < 4; k++)
         frame.push_back(hdr_sum[8 * k +: 8]);
      for (int k = 0; k < 4; k++)
         frame.push_back(body_sum[8 * k +: 8]);
      foreach (body[k])
         frame.push_back(body[k]);
      last = (cut_at >= 0 && cut_at < frame.size()) ? cut_at : frame.size() - 1;
      for (int k = 0; k <= last; k++)
         queue_byte(frame[k], (k == last) && (cut_at >= 0 || end_on_last));
   endtask

   // Noise leans toward sync bytes so that partial and split syncs come up often.
   task automatic add_noise(int unsigned count);
      logic [7:0] b;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(4, 0))
            0: b = SYNC_1;
            1: b = SYNC_2;
            2: b = SYNC_3;
            default: b = 8'($urandom_range(255, 0));
         endcase
         queue_byte(b, $urandom_range(9, 0) == 0);
      end
   endtask

   // Most frames are good; the rest carry one defect each. Sizes stay small except for
   // an occasional long payload, and now and then the largest size the limit allows.
   task automatic add_random_frame();
      int unsigned max_body;
      int unsigned body;
      int unsigned pick;
      int          cut;
      logic [31:0] sz;
      logic [31:0] id;
      logic [15:0] hi16;
      bit          bad_hdr_sum;
      bit          bad_body_sum;
      max_body = (limit_reg > 21) ? limit_reg - 21 : 0;
      body = $urandom_range((max_body < 40) ? max_body : 40, 0);
      if ($urandom_range(39, 0) == 0)
         body = $urandom_range((max_body < 300) ? max_body : 300, 0);
      if ($urandom_range(29, 0) == 0 && max_body <= 300)
         body = max_body;
      sz = HEADER_BYTES + body;
      id = $urandom;
      bad_hdr_sum  = 1'b0;
      bad_body_sum = 1'b0;
      cut = -1;
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
         bad_hdr_sum = 1'b1;
      end else if (pick < 14) begin
         sz   = $urandom_range(HEADER_BYTES - 1, 0);
         body = $urandom_range(8, 0);
      end else if (pick < 18) begin
         sz   = limit_reg + $urandom_range(40, 0);
         body = $urandom_range(8, 0);
      end else if (pick < 20) begin
         // The low half alone would pass; the high half must still reject it.
         hi16 = 16'($urandom_range(65535, 1));
         sz   = {hi16, sz[15:0]};
      end else if (pick < 30) begin
         bad_body_sum = 1'b1;
      end else if (pick < 38) begin
         cut = $urandom_range(HEADER_BYTES - 1 + body, 0);
      end
      add_frame(id, sz, body, bad_hdr_sum, bad_body_sum, cut, $urandom_range(2, 0) == 0);
   endtask

   // ---------------------------------------------------------------------------------
   // Checking.
   // ---------------------------------------------------------------------------------

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         flag_mismatch(what, got, want);
   endtask

   // ---------------------------------------------------------------------------------
   // Byte driver. A byte stays offered until it is taken; a new one is offered only
   // when the slot is free, and the sender may idle instead of offering one.
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      rx_byte_type next_byte;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata, req_tlast);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
               next_byte = rx_bytes_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_byte.data_byte;
               req_tlast  <= next_byte.datagram_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result monitor. It also drives the ready, with random stalls and, on request,
   // one long hold-off that it counts itself.
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      frame_item_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               flag_mismatch("unexpected item, id", rsp_tdata[39:8], '0);
            end else begin
               want = awaited_results.pop_front();
               compare_field("item_type", rsp_tuser, want.item_type);
               compare_field("payload_byte", rsp_tdata[7:0], want.payload_byte);
               compare_field("message_id", rsp_tdata[39:8], want.message_id);
               compare_field("message_size", rsp_tdata[55:40], want.message_size);
               compare_field("status", rsp_tdata[57:56], want.status);
               compare_field("good_frames", rsp_tdata[89:58], want.good_frames);
               compare_field("bad_headers", rsp_tdata[121:90], want.bad_headers);
               compare_field("bad_payloads", rsp_tdata[153:122], want.bad_payloads);
               compare_field("frame_last", rsp_tlast, want.frame_last);
            end
         end
         if (holds_started != hold_requests) begin
            holds_started++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequence.
   // ---------------------------------------------------------------------------------

   // Waits until every queued byte is taken and every expected item has come out, then
   // lets the pipeline empty of bytes that produce no item.
   task automatic wait_idle();
      while (items_accepted != items_queued || awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The limit register is only written while the block is idle.
   task automatic write_size_limit(logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      limit_reg = value;
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned phase_limits[6];
      int unsigned phase_idle[6];
      int unsigned phase_stall[6];
      int unsigned phase_start;
      // Each phase pairs a limit setting with an idling pattern. The limits include the
      // largest value, the smallest legal one and one below it where nothing can pass.
      phase_limits = '{1024, 21, 65535, 300, 20, 777};
      phase_idle   = '{0, 67, 0, 37, 0, 37};
      phase_stall  = '{0, 0, 67, 37, 67, 37};

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      foreach (hdr_mem[k])
         hdr_mem[k] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset limit and with no idling. Extreme byte values, one
      // of them closing a datagram.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hff, 1'b1);
      // An overlapping sync, then a header cut off two bytes in.
      queue_byte(SYNC_1, 1'b0);
      queue_byte(SYNC_1, 1'b0);
      queue_byte(SYNC_2, 1'b0);
      queue_byte(SYNC_3, 1'b0);
      queue_byte(8'h5a, 1'b0);
      queue_byte(8'hff, 1'b1);
      // A sync split across two datagrams must not be found.
      queue_byte(SYNC_1, 1'b0);
      queue_byte(SYNC_2, 1'b1);
      queue_byte(SYNC_3, 1'b0);
      // A frame with an empty payload, so the verdict closes right after the header.
      add_frame(32'hffff_ffff, HEADER_BYTES, 0, 1'b0, 1'b0, -1, 1'b1);
      wait_idle();

      for (int ph = 0; ph < 6; ph++) begin
         write_size_limit(16'(phase_limits[ph]));
         sender_idle_pct    = phase_idle[ph];
         receiver_stall_pct = phase_stall[ph];
         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(3, 0) == 0)
               add_noise($urandom_range(6, 1));
            if ($urandom_range(6, 0) == 0)
               queue_byte(SYNC_1, 1'b0);
            add_random_frame();
         end
         // In the first phase, with no idling on either side, the receiver also holds off for a
         // long stretch while bytes keep coming, so the block fills up and stalls its input.
         if (ph == 0)
            hold_requests++;
         wait_idle();
      end

      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
